### design/assert_macros.svh
// shared assertion macros, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on the clock, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on the clock, also across reset
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALL(label, clk, prop, msg)

`endif

`endif

### design/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

   localparam int MEM_UNITS = 2048;
   localparam int ADDR_W    = $clog2(MEM_UNITS);
   localparam int CNT_W     = $clog2(MEM_UNITS + 1);
   localparam int SIZE_W    = 12;
   localparam int START_W   = 11;
   localparam int CMP_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int STEP_W    = 4;

   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_UNITS - 1);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [SIZE_W-1:0] block_size;
      logic [START_W-1:0] block_start;
   } bfa_req_type;

   typedef struct packed {
      logic               granted;
      logic [START_W-1:0] granted_start;
   } bfa_rsp_type;

   typedef enum logic [2:0] {
      ADDR_HOLD,
      ADDR_INC,
      ADDR_ZERO,
      ADDR_BEST,
      ADDR_REQ
   } addr_op_type;

   typedef enum logic [1:0] {
      MEM_IDLE,
      MEM_READ,
      MEM_CLEAR,
      MEM_MARK
   } mem_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_LAST,
      COND_NO_START,
      COND_IS_FREE,
      COND_NO_AWRITE,
      COND_NO_FWRITE,
      COND_MORE
   } cond_type;

   typedef struct packed {
      addr_op_type       addr_op;
      mem_op_type        mem_op;
      logic              load_req;
      logic              init_scan;
      logic              scan;
      logic              end_run;
      logic              load_rem;
      logic              respond;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic last;
      logic more;
      logic is_free;
      logic no_awrite;
      logic no_fwrite;
   } status_type;

   // microprogram step addresses
   localparam logic [STEP_W-1:0] STEP_CLR      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DRAIN    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FINAL    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_ACHK     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MARK     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RESP     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_FSETUP   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_RELEASE  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_GO       = 4'd11;

   localparam ctrl_type CTRL_NOP = '{
      addr_op:   ADDR_HOLD,
      mem_op:    MEM_IDLE,
      load_req:  1'b0,
      init_scan: 1'b0,
      scan:      1'b0,
      end_run:   1'b0,
      load_rem:  1'b0,
      respond:   1'b0,
      cond:      COND_NEVER,
      target:    STEP_IDLE
   };

   // control store
   function automatic ctrl_type ucode_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = CTRL_NOP;
      case (step)
         STEP_CLR: begin
            w.mem_op  = MEM_CLEAR;
            w.addr_op = ADDR_INC;
            w.cond    = COND_NOT_LAST;
            w.target  = STEP_CLR;
         end
         STEP_IDLE: begin
            w.addr_op   = ADDR_ZERO;
            w.load_req  = 1'b1;
            w.init_scan = 1'b1;
            w.cond      = COND_NO_START;
            w.target    = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.cond   = COND_IS_FREE;
            w.target = STEP_FSETUP;
         end
         STEP_SCAN: begin
            w.mem_op  = MEM_READ;
            w.addr_op = ADDR_INC;
            w.scan    = 1'b1;
            w.cond    = COND_NOT_LAST;
            w.target  = STEP_SCAN;
         end
         STEP_DRAIN: begin
            w.scan = 1'b1;
         end
         STEP_FINAL: begin
            w.end_run = 1'b1;
         end
         STEP_ACHK: begin
            w.addr_op  = ADDR_BEST;
            w.load_rem = 1'b1;
            w.cond     = COND_NO_AWRITE;
            w.target   = STEP_RESP;
         end
         STEP_MARK: begin
            w.mem_op  = MEM_MARK;
            w.addr_op = ADDR_INC;
            w.cond    = COND_MORE;
            w.target  = STEP_MARK;
         end
         STEP_RESP: begin
            w.respond = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = STEP_IDLE;
         end
         STEP_FSETUP: begin
            w.addr_op  = ADDR_REQ;
            w.load_rem = 1'b1;
            w.cond     = COND_NO_FWRITE;
            w.target   = STEP_RESP;
         end
         STEP_RELEASE: begin
            w.mem_op  = MEM_CLEAR;
            w.addr_op = ADDR_INC;
            w.cond    = COND_MORE;
            w.target  = STEP_RELEASE;
         end
         STEP_GO: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_RESP;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### design/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bfa_datapath.sv
`timescale 1ns / 1ps

module bfa_datapath
   import bfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic        start,
   input  bfa_req_type req_data,
   output status_type  status,
   output bfa_rsp_type rsp_data
);

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   bfa_req_type       req_ff, req_in;
   logic [ADDR_W-1:0] pidx_ff;
   logic              pvalid_ff;
   logic              in_run_ff, in_run_in;
   logic [ADDR_W-1:0] run_start_ff, run_start_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] best_start_ff, best_start_in;
   logic [CNT_W-1:0]  best_len_ff, best_len_in;

   logic              ram_we;
   logic              ram_wdata;
   logic              ram_rdata;
   logic              is_free;

   logic              run_close;
   logic [CNT_W-1:0]  cand_end;
   logic [CNT_W-1:0]  cand_len;
   logic              take;

   bfa_ram #(
      .DEPTH(MEM_UNITS),
      .WIDTH(1)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (addr_ff),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign ram_we    = (ctrl.mem_op == MEM_CLEAR) || (ctrl.mem_op == MEM_MARK);
   assign ram_wdata = (ctrl.mem_op == MEM_MARK);
   assign is_free   = (req_ff.req_type == REQ_FREE);

   // run candidate: closed by a used unit, or open at the end of memory
   always_comb begin
      run_close = in_run_ff &&
                  ((ctrl.scan && pvalid_ff && ram_rdata) || ctrl.end_run);
      cand_end  = ctrl.end_run ? CNT_W'(MEM_UNITS) : CNT_W'(pidx_ff);
      cand_len  = cand_end - CNT_W'(run_start_ff);
      take      = run_close &&
                  (CMP_W'(cand_len) >= CMP_W'(req_ff.block_size)) &&
                  (!found_ff || (cand_len < best_len_ff));
   end

   always_comb begin
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      req_in        = req_ff;
      in_run_in     = in_run_ff;
      run_start_in  = run_start_ff;
      found_in      = found_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;

      case (ctrl.addr_op)
         ADDR_HOLD: addr_in = addr_ff;
         ADDR_INC:  addr_in = addr_ff + ADDR_W'(1);
         ADDR_ZERO: addr_in = '0;
         ADDR_BEST: addr_in = best_start_ff;
         ADDR_REQ:  addr_in = ADDR_W'(req_ff.block_start);
         default:   addr_in = addr_ff;
      endcase

      if (ctrl.load_rem) begin
         rem_in = req_ff.block_size;
      end else if (ram_we) begin
         rem_in = rem_ff - SIZE_W'(1);
      end

      if (ctrl.load_req && start) begin
         req_in = req_data;
      end

      if (ctrl.init_scan) begin
         in_run_in = 1'b0;
         found_in  = 1'b0;
      end else begin
         if (ctrl.scan && pvalid_ff) begin
            if (!ram_rdata && !in_run_ff) begin
               in_run_in    = 1'b1;
               run_start_in = pidx_ff;
            end else if (ram_rdata) begin
               in_run_in = 1'b0;
            end
         end
         if (take) begin
            found_in      = 1'b1;
            best_start_in = run_start_ff;
            best_len_in   = cand_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         pvalid_ff <= 1'b0;
         in_run_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         pvalid_ff <= (ctrl.mem_op == MEM_READ);
         in_run_ff <= in_run_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      req_ff        <= req_in;
      pidx_ff       <= addr_ff;
      run_start_ff  <= run_start_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
   end

   always_comb begin
      status.last      = (addr_ff == ADDR_LAST);
      status.more      = (rem_ff != SIZE_W'(1)) && (addr_ff != ADDR_LAST);
      status.is_free   = is_free;
      status.no_awrite = !found_ff || (req_ff.block_size == '0);
      status.no_fwrite = (req_ff.block_size == '0) ||
                         (CMP_W'(req_ff.block_start) >= CMP_W'(MEM_UNITS));
   end

   always_comb begin
      rsp_data.granted       = is_free || found_ff;
      rsp_data.granted_start = (!is_free && found_ff) ? START_W'(best_start_ff) : '0;
   end

endmodule

### design/bfa_sequencer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_sequencer
   import bfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       busy,
   output logic       rsp_strobe
);

   logic [STEP_W-1:0] upc_ff, upc_in;
   logic              jump;

   assign ctrl = ucode_word(upc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:     jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NOT_LAST:  jump = !status.last;
         COND_NO_START:  jump = !start;
         COND_IS_FREE:   jump = status.is_free;
         COND_NO_AWRITE: jump = status.no_awrite;
         COND_NO_FWRITE: jump = status.no_fwrite;
         COND_MORE:      jump = status.more;
         default:        jump = 1'b0;
      endcase
      upc_in = jump ? ctrl.target : upc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign busy       = (upc_ff != STEP_IDLE);
   assign rsp_strobe = ctrl.respond;

   `ASSERT_CLK(a_accept_goes_busy, clock, reset, (start && !busy) |=> busy, "accepted transaction did not start work")
   `ASSERT_CLK(a_resp_returns_idle, clock, reset, rsp_strobe |=> !busy, "sequencer not idle after response")
   `ASSERT_CLK(a_upc_in_program, clock, reset, upc_ff <= STEP_GO, "step counter left the program")
   `ASSERT_ALL(a_reset_clears, clock, reset |=> (upc_ff == STEP_CLR), "reset did not restart the clear pass")

endmodule

### design/best_fit_bitmap_allocator.sv
`timescale 1ns / 1ps
// channel   ports                          handshake
// request   start, busy, req_data          taken when start and not busy
// response  rsp_strobe, rsp_data           one-cycle strobe, no back-pressure
//
// after reset a clear pass writes every bitmap unit free, with busy high
// allocate: a scan of every bitmap unit and a decision, then block_size units marked used
// free: block_size units from block_start released, clipped at the end of memory; none if empty
// the single-port bitmap memory, one unit per cycle, sets the pace of each pass
// the response cannot be stalled; the next request is taken the cycle after it

module best_fit_bitmap_allocator
   import bfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bfa_req_type req_data,
   output logic        rsp_strobe,
   output bfa_rsp_type rsp_data
);

   ctrl_type   ctrl;
   status_type status;

   bfa_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   bfa_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .start   (start),
      .req_data(req_data),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

### verif/tb_best_fit_bitmap_allocator.sv
`timescale 1ns / 1ps

module tb_best_fit_bitmap_allocator;
   import bfa_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 8_000_000;
   localparam int          RANDOM_ITEMS = 266;

   class bitmap_tracker;
      bit          unit_used [MEM_UNITS];
      bfa_rsp_type expected_grants [$];
      bfa_rsp_type last_grant;
      int          mismatches;

      function new();
         foreach (unit_used[i]) unit_used[i] = 1'b0;
         mismatches = 0;
      endfunction

      // predict the response of an accepted transaction and update the bitmap
      function void note_request(bfa_req_type req);
         bfa_rsp_type rsp;
         int unsigned need, first, stop, run_start, run_len, best_start, best_len;
         bit found, in_run;
         need = req.block_size;
         rsp = '0;
         if (req.req_type == REQ_FREE) begin
            first = req.block_start;
            if (first < MEM_UNITS) begin
               stop = first + need;
               if (stop > MEM_UNITS) stop = MEM_UNITS;
               for (int unsigned i = first; i < stop; i++) unit_used[i] = 1'b0;
            end
            rsp.granted = 1'b1;
         end else begin
            found = 1'b0;
            in_run = 1'b0;
            run_start = 0;
            best_start = 0;
            best_len = 0;
            for (int unsigned i = 0; i <= MEM_UNITS; i++) begin
               if (i < MEM_UNITS && !unit_used[i]) begin
                  if (!in_run) begin
                     in_run = 1'b1;
                     run_start = i;
                  end
               end else if (in_run) begin
                  run_len = i - run_start;
                  if (run_len >= need && (!found || run_len < best_len)) begin
                     found = 1'b1;
                     best_start = run_start;
                     best_len = run_len;
                  end
                  in_run = 1'b0;
               end
            end
            if (found) begin
               for (int unsigned i = best_start; i < best_start + need; i++)
                  unit_used[i] = 1'b1;
               rsp.granted = 1'b1;
               rsp.granted_start = START_W'(best_start);
            end
         end
         expected_grants.push_back(rsp);
         last_grant = rsp;
      endfunction

      function void check_response(bfa_rsp_type got);
         bfa_rsp_type exp_rsp;
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected response granted=%0b start=%0d",
                     $realtime, got.granted, got.granted_start);
            mismatches++;
            return;
         end
         exp_rsp = expected_grants.pop_front();
         if (got.granted !== exp_rsp.granted) begin
            $display("%0t: granted expected %0b got %0b",
                     $realtime, exp_rsp.granted, got.granted);
            mismatches++;
         end
         if (got.granted_start !== exp_rsp.granted_start) begin
            $display("%0t: granted_start expected %0d got %0d",
                     $realtime, exp_rsp.granted_start, got.granted_start);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_grants.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   bfa_req_type req_data;
   logic        rsp_strobe;
   bfa_rsp_type rsp_data;

   bitmap_tracker tracker = new();
   int unsigned   cycle_count = 0;
   bit            quiet = 1'b0;
   int unsigned   live_start [$];
   int unsigned   live_size [$];

   best_fit_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_response(rsp_data);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_best_fit_bitmap_allocator: errors");
      $finish;
   end

   // start is left high after acceptance so a zero gap keeps it up
   task automatic issue_request(input logic kind, input int unsigned size,
                                input int unsigned first);
      bfa_req_type item;
      int unsigned gap;
      item.req_type = kind;
      item.block_size = SIZE_W'(size);
      item.block_start = START_W'(first);
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      tracker.note_request(item);
   endtask

   initial begin
      int unsigned pick, size, idx;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge cases
      issue_request(REQ_ALLOC, 0, 0);
      issue_request(REQ_ALLOC, 2048, 2047);
      issue_request(REQ_ALLOC, 0, 0);
      issue_request(REQ_ALLOC, 1, 0);
      issue_request(REQ_FREE, 4095, 2047);
      issue_request(REQ_ALLOC, 1, 5);
      issue_request(REQ_FREE, 2048, 0);
      issue_request(REQ_ALLOC, 2049, 0);
      issue_request(REQ_ALLOC, 4095, 2047);
      issue_request(REQ_ALLOC, 100, 0);
      issue_request(REQ_ALLOC, 50, 0);
      issue_request(REQ_ALLOC, 100, 0);
      issue_request(REQ_ALLOC, 30, 0);
      issue_request(REQ_FREE, 100, 0);
      issue_request(REQ_FREE, 100, 150);
      issue_request(REQ_ALLOC, 60, 1234);
      issue_request(REQ_ALLOC, 40, 0);
      issue_request(REQ_ALLOC, 0, 0);
      issue_request(REQ_FREE, 100, 150);
      issue_request(REQ_FREE, 0, 2047);
      issue_request(REQ_FREE, 4095, 0);
      issue_request(REQ_ALLOC, 2047, 0);
      issue_request(REQ_ALLOC, 1, 0);
      issue_request(REQ_FREE, 2048, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) size = $urandom_range(1, 64);
            else if (pick < 95) size = $urandom_range(65, 300);
            else size = $urandom_range(301, 2048);
            issue_request(REQ_ALLOC, size, $urandom_range(0, 2047));
            if (tracker.last_grant.granted) begin
               live_start.push_back(tracker.last_grant.granted_start);
               live_size.push_back(size);
            end
         end else if (pick < 85 && live_start.size() > 0) begin
            idx = $urandom_range(0, live_start.size() - 1);
            issue_request(REQ_FREE, live_size[idx], live_start[idx]);
            live_start.delete(idx);
            live_size.delete(idx);
         end else begin
            pick = $urandom_range(0, 3);
            case (pick)
               0: issue_request(REQ_ALLOC, 0, $urandom_range(0, 2047));
               1: issue_request(REQ_ALLOC, $urandom_range(2049, 4095),
                                $urandom_range(0, 2047));
               2: issue_request(REQ_FREE, $urandom_range(0, 4095),
                                $urandom_range(0, 2047));
               default: issue_request(REQ_FREE, $urandom_range(0, 64),
                                      $urandom_range(0, 2047));
            endcase
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("tb_best_fit_bitmap_allocator: clean");
      else
         $display("tb_best_fit_bitmap_allocator: errors");
      $finish;
   end

endmodule
